// ===== hdl/modular_inverse_extended_gcd_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef MODULAR_INVERSE_EXTENDED_GCD_CORE_ASSERT_SVH
`define MODULAR_INVERSE_EXTENDED_GCD_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, quiet while in reset.
`define MIEG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, quiet while in reset.
`define MIEG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/minv_pkg.sv =====
`timescale 1ns / 1ps

package minv_pkg;

    localparam int FIELD_W = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ALIGN,
        ST_SUB,
        ST_NEXT,
        ST_FINISH
    } t_state;

endpackage

// ===== hdl/modular_inverse_extended_gcd_core.sv =====
`timescale 1ns / 1ps

// channel  | direction | handshake          | fields
// ---------+-----------+--------------------+-----------------------------------
// input    | in        | i_valid / o_stall  | i_value, i_modulus
// result   | out       | o_valid / i_stall  | o_inverse, o_divisor, o_coprime
//
// One beat in, one beat out. Every division runs through a single shift-subtract
// divider that also accumulates quotient * coefficient, one quotient bit a cycle.
// Each division (the first reduction of value by modulus, then one per Euclid
// step) first aligns the divisor by shifting it left, then shift-subtracts it
// back down; the sequencer adds a start and a finish state, and returns to idle
// to take the next beat.
// Reset is synchronous and clears the sequencer and the result valid.
// o_stall is high from acceptance until the sequencer returns to idle; a held
// result does not block the next input, only the next result write.

module modular_inverse_extended_gcd_core
    import minv_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [FIELD_W-1:0] i_value,
    input  logic [FIELD_W-1:0] i_modulus,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [FIELD_W-1:0] o_inverse,
    output logic [FIELD_W-1:0] o_divisor,
    output logic               o_coprime
);

    localparam int CW = $clog2(WIDTH);

    t_state r_state, n_state;

    logic [WIDTH-1:0] r_a, n_a;
    logic [WIDTH-1:0] r_m, n_m;
    logic [WIDTH-1:0] r_r0, n_r0;
    logic [WIDTH-1:0] r_r1, n_r1;
    logic [WIDTH-1:0] r_s0, n_s0;
    logic [WIDTH-1:0] r_s1, n_s1;
    logic             r_neg0, n_neg0;
    logic             r_neg1, n_neg1;
    logic             r_first, n_first;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_dvs, n_dvs;
    logic [WIDTH-1:0] r_acc, n_acc;
    logic [CW-1:0]    r_cnt, n_cnt;

    logic             r_ovalid, n_ovalid;
    logic [WIDTH-1:0] r_inv, n_inv;
    logic [WIDTH-1:0] r_div, n_div;
    logic             r_ok, n_ok;

    // shared divider datapath
    logic [WIDTH-1:0] cmp_b;
    logic             ge;
    logic [WIDTH-1:0] diff;
    logic             out_free;
    logic             fin_ok;

    assign cmp_b    = (r_state == ST_ALIGN) ? {r_dvs[WIDTH-2:0], 1'b0} : r_dvs;
    assign ge       = (r_rem >= cmp_b);
    assign diff     = r_rem - r_dvs;
    assign out_free = !r_ovalid || !i_stall;
    assign fin_ok   = (r_r0 == WIDTH'(1)) && (r_m != '0);

    assign o_stall   = (r_state != ST_IDLE);
    assign o_valid   = r_ovalid;
    assign o_inverse = FIELD_W'(r_inv);
    assign o_divisor = FIELD_W'(r_div);
    assign o_coprime = r_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_first  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_first  <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_m    <= n_m;
        r_r0   <= n_r0;
        r_r1   <= n_r1;
        r_s0   <= n_s0;
        r_s1   <= n_s1;
        r_neg0 <= n_neg0;
        r_neg1 <= n_neg1;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_acc  <= n_acc;
        r_cnt  <= n_cnt;
        r_inv  <= n_inv;
        r_div  <= n_div;
        r_ok   <= n_ok;
    end

    always_comb begin
        n_state  = r_state;
        n_a      = r_a;
        n_m      = r_m;
        n_r0     = r_r0;
        n_r1     = r_r1;
        n_s0     = r_s0;
        n_s1     = r_s1;
        n_neg0   = r_neg0;
        n_neg1   = r_neg1;
        n_first  = r_first;
        n_rem    = r_rem;
        n_dvs    = r_dvs;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_inv    = r_inv;
        n_div    = r_div;
        n_ok     = r_ok;
        n_ovalid = r_ovalid;

        // drop the result once the beat is taken
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_a     = WIDTH'(i_value);
                    n_m     = WIDTH'(i_modulus);
                    n_state = ST_START;
                end
            end
            ST_START: begin
                n_s0   = '0;
                n_neg0 = 1'b0;
                if (r_m == '0) begin
                    n_r0    = r_a;
                    n_state = ST_FINISH;
                end else begin
                    // reduce value by modulus first
                    n_r0    = r_m;
                    n_rem   = r_a;
                    n_dvs   = r_m;
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_first = 1'b1;
                    n_state = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                if (!r_dvs[WIDTH-1] && ge) begin
                    n_dvs = {r_dvs[WIDTH-2:0], 1'b0};
                    n_cnt = r_cnt + CW'(1);
                end else begin
                    n_state = ST_SUB;
                end
            end
            ST_SUB: begin
                if (ge) begin
                    n_rem = diff;
                end
                n_acc = {r_acc[WIDTH-2:0], 1'b0} + (ge ? r_s1 : '0);
                if (r_cnt == '0) begin
                    n_state = ST_NEXT;
                end else begin
                    n_dvs = {1'b0, r_dvs[WIDTH-1:1]};
                    n_cnt = r_cnt - CW'(1);
                end
            end
            ST_NEXT: begin
                if (r_first) begin
                    n_r1    = r_rem;
                    n_s0    = '0;
                    n_s1    = WIDTH'(1);
                    n_neg0  = 1'b0;
                    n_neg1  = 1'b0;
                    n_first = 1'b0;
                end else begin
                    n_r0   = r_r1;
                    n_r1   = r_rem;
                    n_s0   = r_s1;
                    n_s1   = r_acc + r_s0;
                    n_neg0 = r_neg1;
                    n_neg1 = !r_neg1;
                end
                if (r_rem == '0) begin
                    n_state = ST_FINISH;
                end else begin
                    n_rem   = n_r0;
                    n_dvs   = r_rem;
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_state = ST_ALIGN;
                end
            end
            ST_FINISH: begin
                // hold until the previous result has left
                if (out_free) begin
                    n_div    = r_r0;
                    n_ok     = fin_ok;
                    if (!fin_ok) begin
                        n_inv = '0;
                    end else if (r_neg0 && (r_s0 != '0)) begin
                        n_inv = r_m - r_s0;
                    end else begin
                        n_inv = r_s0;
                    end
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/minv_checker.sv =====
`timescale 1ns / 1ps

`include "modular_inverse_extended_gcd_core_assert.svh"

module minv_checker
    import minv_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic [FIELD_W-1:0] o_inverse,
    input logic [FIELD_W-1:0] o_divisor,
    input logic               o_coprime
);

    `MIEG_ASSERT_NOW(a_coprime_div_one, o_valid && o_coprime, o_divisor == FIELD_W'(1), "coprime result without unit divisor")
    `MIEG_ASSERT_NOW(a_noinv_zero, o_valid && !o_coprime, o_inverse == '0, "inverse nonzero on non-coprime result")
    `MIEG_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall, "input accepted while not busy afterwards")
    `MIEG_ASSERT_NEXT(a_result_held, o_valid && i_stall, o_valid && $stable(o_divisor), "stalled result beat changed")

endmodule

bind modular_inverse_extended_gcd_core minv_checker u_minv_checker (.*);
